FILE: rtl/core/gbd_pkg.sv
// Shared types and constants for the grid distance map block.
`timescale 1ns / 1ps
package gbd_pkg;

	localparam int ROW_W   = 10;
	localparam int COL_W   = 10;
	localparam int ADDR_W  = ROW_W + COL_W;
	localparam int DIM_W   = 11;
	localparam int DIST_W  = 20;
	localparam int OUT_W   = 21;
	localparam int EPOCH_W = 8;
	localparam int CNT_W   = ADDR_W + 1;

	localparam logic [DIM_W-1:0]   MAX_ROWS_C = DIM_W'(1 << ROW_W);
	localparam logic [DIM_W-1:0]   MAX_COLS_C = DIM_W'(1 << COL_W);
	localparam logic [DIST_W-1:0]  DIST_SAT   = {DIST_W{1'b1}};
	localparam logic [EPOCH_W-1:0] EPOCH_LAST = {EPOCH_W{1'b1}};
	localparam logic [CNT_W-1:0]   CELL_COUNT = CNT_W'(1) << ADDR_W;

	// request ops
	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	// register indexes
	localparam logic [1:0] REG_ROWS = 2'd0;
	localparam logic [1:0] REG_COLS = 2'd1;

	// cell codes
	localparam logic [1:0] CELL_BLOCKED = 2'd0;
	localparam logic [1:0] CELL_TARGET  = 2'd2;

	// neighbor directions
	localparam logic [1:0] DIR_EAST  = 2'd0;
	localparam logic [1:0] DIR_WEST  = 2'd1;
	localparam logic [1:0] DIR_SOUTH = 2'd2;
	localparam logic [1:0] DIR_NORTH = 2'd3;

	// store access from the sequencer
	typedef struct packed {
		logic                rd_en;
		logic [ADDR_W-1:0]   rd_addr;
		logic                cell_we;
		logic [ADDR_W-1:0]   cell_addr;
		logic [1:0]          cell_data;
		logic                dist_we;
		logic [ADDR_W-1:0]   dist_addr;
		logic [DIST_W-1:0]   dist_data;
		logic [EPOCH_W-1:0]  tag_data;
	} st_req_t;

	typedef struct packed {
		logic [1:0]          cell_rd;
		logic [DIST_W-1:0]   dist_rd;
		logic [EPOCH_W-1:0]  tag;
	} st_rsp_t;

	// clamp a configured dimension into 1..max
	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
		input logic [DIM_W-1:0] maxv);
		logic [DIM_W-1:0] r;
		r = v;
		if (v == '0) r = DIM_W'(1);
		else if (v > maxv) r = maxv;
		return r;
	endfunction

endpackage

FILE: rtl/core/gbd_store.sv
// Cell, distance and epoch tag memories, one shared registered read port.
`timescale 1ns / 1ps
module gbd_store import gbd_pkg::*; (
	input  logic    clk,
	input  st_req_t req,
	output st_rsp_t rsp
);

	logic [1:0]         cell_mem [0:(1<<ADDR_W)-1];
	logic [DIST_W-1:0]  dist_mem [0:(1<<ADDR_W)-1];
	logic [EPOCH_W-1:0] tag_mem  [0:(1<<ADDR_W)-1];
	st_rsp_t            rsp_q;

	// writes
	always_ff @(posedge clk) begin
		if (req.cell_we) cell_mem[req.cell_addr] <= req.cell_data;
		if (req.dist_we) begin
			dist_mem[req.dist_addr] <= req.dist_data;
			tag_mem[req.dist_addr]  <= req.tag_data;
		end
	end

	// registered read, held between reads
	always_ff @(posedge clk) begin
		if (req.rd_en) begin
			rsp_q.cell_rd <= cell_mem[req.rd_addr];
			rsp_q.dist_rd <= dist_mem[req.rd_addr];
			rsp_q.tag     <= tag_mem[req.rd_addr];
		end
	end

	assign rsp = rsp_q;

endmodule

FILE: rtl/core/gbd_queue.sv
// Frontier FIFO of cell addresses for the breadth-first sweep.
`timescale 1ns / 1ps
module gbd_queue import gbd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              clear,
	input  logic              push,
	input  logic [ADDR_W-1:0] push_data,
	input  logic              pop,
	output logic [ADDR_W-1:0] pop_data,
	output logic              empty
);

	logic [ADDR_W-1:0] mem [0:(1<<ADDR_W)-1];
	logic [CNT_W-1:0]  head_q, tail_q;
	logic [ADDR_W-1:0] rdata_q;

	// pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
		end else if (clear) begin
			head_q <= '0;
			tail_q <= '0;
		end else begin
			if (push && tail_q < CELL_COUNT) tail_q <= tail_q + CNT_W'(1);
			if (pop) head_q <= head_q + CNT_W'(1);
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push && tail_q < CELL_COUNT) mem[tail_q[ADDR_W-1:0]] <= push_data;
		if (pop) rdata_q <= mem[head_q[ADDR_W-1:0]];
	end

	assign pop_data = rdata_q;
	assign empty    = (head_q == tail_q);

endmodule

FILE: rtl/core/grid_bfs_distance_map_top.sv
// Grid distance map: cell load, breadth-first search sequencer, distance query.
//
//  channel | signals                               | role
//  in      | in_valid in_stall op row col cell_value | load / query requests
//  out     | out_valid out_stall distance          | one result per query
//  cfg     | cfg_valid cfg_ready cfg_index cfg_data | grid_rows, grid_cols
//
// A load is written as it is accepted and leaves the sequencer idle. When the
// grid changed since the last search, a query first runs a search, which reads
// the single store read port once per reached cell and once per in-area neighbor.
// The first search after reset and every 255th one after it first sweeps
// all 2^20 epoch tags.
// Reset leaves the cell store undefined; the first query always searches.
// A stalled result holds the query path; in_stall is high while busy.
`timescale 1ns / 1ps
module grid_bfs_distance_map_top import gbd_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic                    op,
	input  logic [ROW_W-1:0]        row,
	input  logic [COL_W-1:0]        col,
	input  logic [1:0]              cell_value,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic signed [OUT_W-1:0] distance,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [1:0]              cfg_index,
	input  logic [DIM_W-1:0]        cfg_data
);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_CLR  = 4'd1;
	localparam logic [3:0] S_INIT = 4'd2;
	localparam logic [3:0] S_POP  = 4'd3;
	localparam logic [3:0] S_CUR  = 4'd4;
	localparam logic [3:0] S_CURD = 4'd5;
	localparam logic [3:0] S_NB   = 4'd6;
	localparam logic [3:0] S_CHK  = 4'd7;
	localparam logic [3:0] S_QRD  = 4'd8;
	localparam logic [3:0] S_QOUT = 4'd9;

	logic [3:0]         state_q;
	logic [DIM_W-1:0]   rows_q, cols_q, rows_eff, cols_eff;
	logic [ROW_W-1:0]   trow_q, qrow_q, crow, nrow;
	logic [COL_W-1:0]   tcol_q, qcol_q, ccol, ncol;
	logic               stale_q, qin_q, nb_ok;
	logic [EPOCH_W-1:0] epoch_q;
	logic [ADDR_W-1:0]  clr_q, cur_q, nb_q;
	logic [DIST_W-1:0]  d_q, d_next;
	logic [1:0]         k_q;
	logic               out_valid_q;
	logic [OUT_W-1:0]   dist_q, qres;
	logic               in_acc, out_free, reached;
	st_req_t            st_req;
	st_rsp_t            st_rsp;
	logic               q_clear, q_push, q_pop, q_empty;
	logic [ADDR_W-1:0]  q_push_data, q_pop_data;

	gbd_store u_store (.clk(clk), .req(st_req), .rsp(st_rsp));

	gbd_queue u_queue (
		.clk(clk), .arst_n(arst_n), .clear(q_clear), .push(q_push),
		.push_data(q_push_data), .pop(q_pop), .pop_data(q_pop_data), .empty(q_empty)
	);

	assign rows_eff = clamp_dim(rows_q, MAX_ROWS_C);
	assign cols_eff = clamp_dim(cols_q, MAX_COLS_C);
	assign in_stall = (state_q != S_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign cfg_ready = 1'b1;
	assign out_free = !out_valid_q || !out_stall;
	assign crow = cur_q[ADDR_W-1:COL_W];
	assign ccol = cur_q[COL_W-1:0];
	assign d_next = (d_q == DIST_SAT) ? DIST_SAT : d_q + DIST_W'(1);
	assign reached = (st_rsp.tag == epoch_q) && (st_rsp.cell_rd != CELL_BLOCKED);

	// neighbor address unit
	always_comb begin
		nrow  = crow;
		ncol  = ccol;
		nb_ok = 1'b0;
		case (k_q)
			DIR_EAST: begin
				ncol  = ccol + COL_W'(1);
				nb_ok = ({1'b0, ccol} + DIM_W'(1)) < cols_eff;
			end
			DIR_WEST: begin
				ncol  = ccol - COL_W'(1);
				nb_ok = (ccol != '0);
			end
			DIR_SOUTH: begin
				nrow  = crow + ROW_W'(1);
				nb_ok = ({1'b0, crow} + DIM_W'(1)) < rows_eff;
			end
			DIR_NORTH: begin
				nrow  = crow - ROW_W'(1);
				nb_ok = (crow != '0);
			end
			default: nb_ok = 1'b0;
		endcase
	end

	// query result
	always_comb begin
		if (!qin_q) qres = {OUT_W{1'b1}};
		else if (st_rsp.cell_rd == CELL_BLOCKED) qres = '0;
		else if (st_rsp.tag == epoch_q) qres = {1'b0, st_rsp.dist_rd};
		else qres = {OUT_W{1'b1}};
	end

	// store and queue access
	always_comb begin
		st_req           = '0;
		st_req.cell_we   = in_acc && (op == OP_LOAD);
		st_req.cell_addr = {row, col};
		st_req.cell_data = cell_value;
		q_clear          = 1'b0;
		q_push           = 1'b0;
		q_push_data      = {trow_q, tcol_q};
		q_pop            = 1'b0;
		case (state_q)
			S_IDLE: q_clear = in_acc && (op == OP_QUERY) && stale_q;
			S_CLR: begin
				st_req.dist_we   = 1'b1;
				st_req.dist_addr = clr_q;
				st_req.tag_data  = '0;
			end
			S_INIT: begin
				if ({1'b0, trow_q} < rows_eff && {1'b0, tcol_q} < cols_eff) begin
					st_req.dist_we   = 1'b1;
					st_req.dist_addr = {trow_q, tcol_q};
					st_req.dist_data = '0;
					st_req.tag_data  = epoch_q;
					q_push           = 1'b1;
				end
			end
			S_POP: q_pop = !q_empty;
			S_CUR: begin
				st_req.rd_en   = 1'b1;
				st_req.rd_addr = q_pop_data;
			end
			S_NB: begin
				st_req.rd_en   = nb_ok;
				st_req.rd_addr = {nrow, ncol};
			end
			S_CHK: begin
				if (!reached && st_rsp.cell_rd != CELL_BLOCKED) begin
					st_req.dist_we   = 1'b1;
					st_req.dist_addr = nb_q;
					st_req.dist_data = d_next;
					st_req.tag_data  = epoch_q;
					q_push           = 1'b1;
					q_push_data      = nb_q;
				end
			end
			S_QRD: begin
				// in-area check lands with the read; the result ignores it outside
				st_req.rd_en   = 1'b1;
				st_req.rd_addr = {qrow_q, qcol_q};
			end
			default: ;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rows_q      <= MAX_ROWS_C;
			cols_q      <= MAX_COLS_C;
			trow_q      <= '0;
			tcol_q      <= '0;
			stale_q     <= 1'b1;
			epoch_q     <= EPOCH_LAST;
			clr_q       <= '0;
			k_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_ROWS) begin
					rows_q  <= cfg_data;
					stale_q <= 1'b1;
				end else if (cfg_index == REG_COLS) begin
					cols_q  <= cfg_data;
					stale_q <= 1'b1;
				end
			end
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						if (op == OP_LOAD) begin
							stale_q <= 1'b1;
							if (cell_value == CELL_TARGET) begin
								trow_q <= row;
								tcol_q <= col;
							end
						end else if (stale_q) begin
							stale_q <= 1'b0;
							clr_q   <= '0;
							if (epoch_q == EPOCH_LAST) state_q <= S_CLR;
							else begin
								epoch_q <= epoch_q + EPOCH_W'(1);
								state_q <= S_INIT;
							end
						end else state_q <= S_QRD;
					end
				end
				S_CLR: begin
					clr_q <= clr_q + ADDR_W'(1);
					if (clr_q == {ADDR_W{1'b1}}) begin
						epoch_q <= EPOCH_W'(1);
						state_q <= S_INIT;
					end
				end
				S_INIT: state_q <= S_POP;
				S_POP: state_q <= q_empty ? S_QRD : S_CUR;
				S_CUR: begin
					cur_q   <= q_pop_data;
					state_q <= S_CURD;
				end
				S_CURD: begin
					d_q     <= st_rsp.dist_rd;
					k_q     <= DIR_EAST;
					state_q <= S_NB;
				end
				S_NB: begin
					if (nb_ok) begin
						nb_q    <= {nrow, ncol};
						state_q <= S_CHK;
					end else if (k_q == DIR_NORTH) state_q <= S_POP;
					else k_q <= k_q + 2'd1;
				end
				S_CHK: begin
					if (k_q == DIR_NORTH) state_q <= S_POP;
					else begin
						k_q     <= k_q + 2'd1;
						state_q <= S_NB;
					end
				end
				S_QRD: state_q <= S_QOUT;
				S_QOUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// query latch and result payload
	always_ff @(posedge clk) begin
		if (in_acc) begin
			qrow_q <= row;
			qcol_q <= col;
		end
		if (state_q == S_QRD || state_q == S_POP)
			qin_q <= ({1'b0, qrow_q} < rows_eff) && ({1'b0, qcol_q} < cols_eff);
		if (state_q == S_QOUT && out_free) dist_q <= qres;
	end

	assign out_valid = out_valid_q;
	assign distance  = signed'(dist_q);

	// checks
	a_out_from_query: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q) == S_QOUT)
		else $error("result raised outside query output");
	a_epoch_live: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_INIT) |-> epoch_q != '0)
		else $error("search started with cleared epoch");
	a_push_in_search: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> (state_q == S_INIT || state_q == S_CHK))
		else $error("frontier push outside search");
	a_no_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		st_req.cell_we |-> $past(state_q) != S_QRD && state_q == S_IDLE)
		else $error("cell write while sequencer busy");

endmodule

FILE: verif/grid_bfs_distance_map_checker.sv
// Request/result monitor with a distance predictor and in-order result compare.
`timescale 1ns / 1ps
module grid_bfs_distance_map_checker import gbd_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	input  logic                    in_stall,
	input  logic                    op,
	input  logic [ROW_W-1:0]        row,
	input  logic [COL_W-1:0]        col,
	input  logic [1:0]              cell_value,
	input  logic                    out_valid,
	input  logic                    out_stall,
	input  logic signed [OUT_W-1:0] distance,
	input  logic                    cfg_valid,
	input  logic                    cfg_ready,
	input  logic [1:0]              cfg_index,
	input  logic [DIM_W-1:0]        cfg_data,
	output int                      fail_count,
	output int                      pending
);

	// mirrored block state
	logic [1:0]        cell_mem[int];
	int                step_map[int];
	logic [DIM_W-1:0]  rows_reg, cols_reg;
	int                tgt_r, tgt_c;
	bit                stale;
	logic signed [OUT_W-1:0] dist_q[$];

	assign pending = dist_q.size();

	task automatic report(input string what);
		$display("[%0t] mismatch: %s", $realtime, what);
		fail_count++;
	endtask

	function automatic int eff_dim(input logic [DIM_W-1:0] v, input int maxv);
		if (v == 0) return 1;
		if (v > maxv) return maxv;
		return v;
	endfunction

	function automatic logic [1:0] cell_at(input int a);
		if (cell_mem.exists(a)) return cell_mem[a];
		return CELL_BLOCKED;
	endfunction

	// breadth-first fill of step_map from the target
	function automatic void flood(input int nrows, input int ncols);
		int fifo[$];
		int cur, r, c, nr, nc, n, k, d;
		int dr[4] = '{0, 0, 1, -1};
		int dc[4] = '{1, -1, 0, 0};
		step_map.delete();
		if (tgt_r >= nrows || tgt_c >= ncols) return;
		cur = tgt_r * 1024 + tgt_c;
		step_map[cur] = 0;
		fifo.push_back(cur);
		while (fifo.size() > 0) begin
			cur = fifo.pop_front();
			r = cur / 1024;
			c = cur % 1024;
			d = step_map[cur];
			for (k = 0; k < 4; k++) begin
				nr = r + dr[k];
				nc = c + dc[k];
				if (nr < 0 || nc < 0 || nr >= nrows || nc >= ncols) continue;
				n = nr * 1024 + nc;
				if (step_map.exists(n) || cell_at(n) == CELL_BLOCKED) continue;
				step_map[n] = (d >= 1048575) ? 1048575 : d + 1;
				fifo.push_back(n);
			end
		end
	endfunction

	function automatic logic signed [OUT_W-1:0] query_distance(input int r, input int c);
		int nrows, ncols, a;
		nrows = eff_dim(rows_reg, 1024);
		ncols = eff_dim(cols_reg, 1024);
		if (stale) begin
			flood(nrows, ncols);
			stale = 0;
		end
		if (r >= nrows || c >= ncols) return OUT_W'(-1);
		a = r * 1024 + c;
		if (cell_at(a) == CELL_BLOCKED) return '0;
		if (step_map.exists(a)) return OUT_W'(step_map[a]);
		return OUT_W'(-1);
	endfunction

	// watch all three channels
	always @(posedge clk or negedge arst_n) begin
		logic signed [OUT_W-1:0] want;
		if (!arst_n) begin
			rows_reg = 11'd1024;
			cols_reg = 11'd1024;
			tgt_r = 0;
			tgt_c = 0;
			stale = 1;
			dist_q.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_ROWS) begin
					rows_reg = cfg_data;
					stale = 1;
				end else if (cfg_index == REG_COLS) begin
					cols_reg = cfg_data;
					stale = 1;
				end
			end
			if (out_valid && !out_stall) begin
				if (dist_q.size() == 0) begin
					report($sformatf("unexpected result distance=%0d", distance));
				end else begin
					want = dist_q.pop_front();
					if (distance !== want)
						report($sformatf("distance got %0d want %0d", distance, want));
				end
			end
			if (in_valid && !in_stall) begin
				if (op == OP_LOAD) begin
					cell_mem[row * 1024 + col] = cell_value;
					if (cell_value == CELL_TARGET) begin
						tgt_r = row;
						tgt_c = col;
					end
					stale = 1;
				end else begin
					dist_q.push_back(query_distance(row, col));
				end
			end
		end
	end

	initial fail_count = 0;

endmodule

FILE: verif/testbench.sv
// Stimulus, handshake pacing and verdict for the grid distance map block.
`timescale 1ns / 1ps
module testbench;
	import gbd_pkg::*;

	logic                    clk;
	logic                    arst_n;
	logic                    in_valid;
	logic                    in_stall;
	logic                    op;
	logic [ROW_W-1:0]        row;
	logic [COL_W-1:0]        col;
	logic [1:0]              cell_value;
	logic                    out_valid;
	logic                    out_stall;
	logic signed [OUT_W-1:0] distance;
	logic                    cfg_valid;
	logic                    cfg_ready;
	logic [1:0]              cfg_index;
	logic [DIM_W-1:0]        cfg_data;
	int                      fail_count;
	int                      pending;

	bit quiet;      // no idling on either side
	bit hold_req;   // ask the receiver for a long hold-off
	int area_r, area_c;

	grid_bfs_distance_map_top uut (.*);

	grid_bfs_distance_map_checker chk (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#200_000_000;
		$display("testbench: FAIL");
		$finish;
	end

	function automatic int pick_gap();
		int p;
		if (quiet) return 0;
		p = $urandom_range(99);
		if (p < 60) return 0;
		if (p < 92) return $urandom_range(1, 3);
		return $urandom_range(5, 40);
	endfunction

	// receiver stall pattern
	initial begin
		int n;
		out_stall = 0;
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				out_stall <= 1;
				repeat (3000) @(posedge clk);
				hold_req = 0;
			end
			n = pick_gap();
			out_stall <= (n > 0);
			repeat (n > 0 ? n : 1) @(posedge clk);
			if (n > 0) begin
				out_stall <= 0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
		end
	end

	task automatic send_req(input logic o, input int r, input int c, input int v);
		int g;
		g = pick_gap();
		if (g > 0) begin
			in_valid <= 0;
			repeat (g) @(posedge clk);
		end
		in_valid <= 1;
		op <= o;
		row <= ROW_W'(r);
		col <= COL_W'(c);
		cell_value <= 2'(v);
		do @(posedge clk); while (in_stall);
	endtask

	// drain: let the checker see the last request, then wait for all results
	task automatic wait_idle();
		in_valid <= 0;
		@(posedge clk);
		while (pending != 0 || in_stall) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [DIM_W-1:0] v);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic set_area(input logic [DIM_W-1:0] r, input logic [DIM_W-1:0] c);
		wait_idle();
		write_reg(REG_ROWS, r);
		write_reg(REG_COLS, c);
		cfg_valid <= 0;
		area_r = (r == 0) ? 1 : (r > 1024 ? 1024 : r);
		area_c = (c == 0) ? 1 : (c > 1024 ? 1024 : c);
	endtask

	function automatic logic [1:0] rand_cell();
		int p;
		p = $urandom_range(99);
		if (p < 22) return CELL_BLOCKED;
		if (p < 92) return 2'd1;
		return 2'd3;
	endfunction

	// load every cell of the area, then place a target
	task automatic fill_area();
		int r, c;
		for (r = 0; r < area_r; r++)
			for (c = 0; c < area_c; c++)
				send_req(OP_LOAD, r, c, rand_cell());
		send_req(OP_LOAD, $urandom_range(area_r - 1), $urandom_range(area_c - 1), CELL_TARGET);
	endtask

	// random mix: mostly queries, short load bursts re-stale the search
	task automatic random_mix(input int count, input int load_pct);
		int k, j, p;
		for (k = 0; k < count; k++) begin
			p = $urandom_range(99);
			if (p < load_pct) begin
				for (j = $urandom_range(1, 3); j > 0; j--) begin
					if ($urandom_range(9) == 0)
						send_req(OP_LOAD, $urandom_range(1023), $urandom_range(1023),
							$urandom_range(3));
					else
						send_req(OP_LOAD, $urandom_range(area_r - 1),
							$urandom_range(area_c - 1), $urandom_range(3));
					k++;
				end
			end else if (p < load_pct + 12) begin
				send_req(OP_QUERY, $urandom_range(1023), $urandom_range(1023),
					$urandom_range(3));
			end else begin
				send_req(OP_QUERY, $urandom_range(area_r - 1), $urandom_range(area_c - 1),
					$urandom_range(3));
			end
			if ($urandom_range(199) == 0) begin
				in_valid <= 0;
				@(posedge clk);
				while (pending != 0) @(posedge clk);
			end
		end
	endtask

	task automatic random_phase(input logic [DIM_W-1:0] r, input logic [DIM_W-1:0] c,
		input int count, input int load_pct);
		set_area(r, c);
		quiet = ($urandom_range(3) == 0);
		fill_area();
		random_mix(count, load_pct);
		quiet = 0;
	endtask

	initial begin
		arst_n = 0;
		in_valid = 0;
		op = OP_LOAD;
		row = 0;
		col = 0;
		cell_value = 0;
		cfg_valid = 0;
		cfg_index = REG_ROWS;
		cfg_data = 0;
		quiet = 0;
		hold_req = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: 3x4 grid with a wall, a value-three cell and special targets
		set_area(11'd3, 11'd4);
		send_req(OP_LOAD, 0, 0, 2'd1);
		send_req(OP_LOAD, 0, 1, 2'd1);
		send_req(OP_LOAD, 0, 2, CELL_BLOCKED);
		send_req(OP_LOAD, 0, 3, 2'd1);
		send_req(OP_LOAD, 1, 0, 2'd3);
		send_req(OP_LOAD, 1, 1, CELL_TARGET);
		send_req(OP_LOAD, 1, 2, CELL_BLOCKED);
		send_req(OP_LOAD, 1, 3, 2'd1);
		send_req(OP_LOAD, 2, 0, 2'd1);
		send_req(OP_LOAD, 2, 1, 2'd1);
		send_req(OP_LOAD, 2, 2, CELL_BLOCKED);
		send_req(OP_LOAD, 2, 3, 2'd1);
		send_req(OP_QUERY, 1, 1, 2'd0);
		send_req(OP_QUERY, 2, 0, 2'd3);
		send_req(OP_QUERY, 0, 2, 2'd0);
		send_req(OP_QUERY, 1, 3, 2'd0);
		send_req(OP_QUERY, 1023, 1023, 2'd3);
		// target far outside the area: nothing reachable
		send_req(OP_LOAD, 1023, 1023, CELL_TARGET);
		send_req(OP_QUERY, 0, 0, 2'd0);
		// blocked target at the origin
		send_req(OP_LOAD, 0, 0, CELL_TARGET);
		send_req(OP_LOAD, 0, 0, CELL_BLOCKED);
		send_req(OP_QUERY, 0, 0, 2'd0);
		send_req(OP_QUERY, 2, 1, 2'd0);

		// smallest area, then an 8x8 area
		random_phase(11'd1, 11'd1, 30, 20);
		random_phase(11'd8, 11'd8, 100, 15);

		// long receiver hold-off while queries keep coming
		hold_req = 1;
		random_mix(60, 0);

		random_phase(11'd0, 11'd2047, 40, 4);
		random_phase(11'd5, 11'd7, 100, 20);
		random_phase(11'd16, 11'd4, 80, 15);
		random_phase(11'd6, 11'd6, 100, 20);

		wait_idle();
		repeat (50) @(posedge clk);
		if (fail_count == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

endmodule
